// ===== hdl/mirb_pkg.sv =====
package mirb_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int REPORT_BUTTONS = 5;
    localparam int MIDDLE_BUTTON = 2;

    localparam logic [7:0] DEBOUNCE_TIME_RESET = 8'd200;

    // always level-driven buttons (no edge flag)
    localparam logic [5:0] ALWAYS_LEVEL_MASK = 6'b110000;

    localparam logic [7:0] STEP_DOWN_FLAG = 8'h40;
    localparam logic [7:0] STEP_UP_FLAG = 8'h80;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [1:0] CFG_INVERT_X = 2'd1;
    localparam logic [1:0] CFG_INVERT_Y = 2'd2;
    localparam logic [1:0] CFG_INVERT_WHEEL = 2'd3;

    typedef struct packed {
        logic [5:0]         button_levels;
        logic [3:0]         edge_seen;
        logic [1:0]         wheel_pins;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic               bank_busy;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         debounced_buttons;
        logic               kill_bank;
        logic               send_report;
        logic [4:0]         report_buttons;
        logic signed [15:0] report_x;
        logic signed [15:0] report_y;
        logic signed [7:0]  report_wheel;
    } out_item_t;

    // half-step quadrature table, rows beyond five fall back to row zero
    function automatic logic [7:0] half_step_row(input logic [3:0] row, input logic [1:0] pins);
        logic [7:0] entry;
        begin
            entry = 8'h00;
            case (row)
                4'd1:
                begin
                    case (pins)
                        2'd0: entry = 8'h83;
                        2'd1: entry = 8'h00;
                        2'd2: entry = 8'h01;
                        default: entry = 8'h00;
                    endcase
                end
                4'd2:
                begin
                    case (pins)
                        2'd0: entry = 8'h43;
                        2'd1: entry = 8'h02;
                        2'd2: entry = 8'h00;
                        default: entry = 8'h00;
                    endcase
                end
                4'd3:
                begin
                    case (pins)
                        2'd0: entry = 8'h03;
                        2'd1: entry = 8'h05;
                        2'd2: entry = 8'h04;
                        default: entry = 8'h00;
                    endcase
                end
                4'd4:
                begin
                    case (pins)
                        2'd0: entry = 8'h03;
                        2'd1: entry = 8'h03;
                        2'd2: entry = 8'h04;
                        default: entry = 8'h40;
                    endcase
                end
                4'd5:
                begin
                    case (pins)
                        2'd0: entry = 8'h03;
                        2'd1: entry = 8'h05;
                        2'd2: entry = 8'h03;
                        default: entry = 8'h80;
                    endcase
                end
                default:
                begin
                    case (pins)
                        2'd0: entry = 8'h03;
                        2'd1: entry = 8'h02;
                        2'd2: entry = 8'h01;
                        default: entry = 8'h00;
                    endcase
                end
            endcase
            return entry;
        end
    endfunction

endpackage

// ===== hdl/mouse_input_report_builder.sv =====
// mouse input report builder, one input transfer per sensor tick
// in channel: in_valid / in_ready with in_data (levels, edges, wheel pins,
//   dx, dy, bank busy); one result transfer on out_valid / out_ready per tick
// config: cfg_write with cfg_index / cfg_data, written by the user while idle; the block does not enforce it
// path: the input transfer is captured in the input register, then the debounce,
//   wheel and accumulate logic writes the result register, which drives out_valid
// throughput: one tick per cycle; the input register and result register form
//   a two-stage pipeline that advances whenever the result slot is free
// reset: all debounce timers, wheel state and accumulators clear to zero,
//   debounce time goes to 200 ticks and all inversions off
// receiver stall: the result register holds, the input register fills and
//   in_ready drops until out_ready returns; no transfer is lost or repeated
module mouse_input_report_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mirb_pkg::in_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mirb_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic [7:0] debounce_time_reg;
    logic       invert_x_reg;
    logic       invert_y_reg;
    logic       invert_wheel_reg;

    logic                in_valid_reg;
    mirb_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg;
    mirb_pkg::out_item_t out_data_reg;
    mirb_pkg::out_item_t out_data_next;

    logic [5:0] prev_debounced_reg, prev_debounced_next;
    logic [7:0] release_timer_reg [mirb_pkg::NUM_BUTTONS];
    logic [7:0] release_timer_next [mirb_pkg::NUM_BUTTONS];
    logic [7:0] wheel_state_reg, wheel_state_next;
    logic [1:0] last_pins_reg, last_pins_next;
    logic [4:0] acc_buttons_reg, acc_buttons_next;
    logic [4:0] sent_buttons_reg, sent_buttons_next;
    logic [15:0] acc_x_reg, acc_x_next;
    logic [15:0] acc_y_reg, acc_y_next;
    logic [7:0] acc_wheel_reg, acc_wheel_next;

    logic advance;
    logic [5:0] released;
    logic [7:0] timer_inc;
    logic [7:0] step;
    logic changed;
    logic send;
    logic [4:0] base_buttons;
    logic [15:0] base_x, base_y;
    logic [7:0] base_wheel;

    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg <= mirb_pkg::DEBOUNCE_TIME_RESET;
            invert_x_reg <= 1'b0;
            invert_y_reg <= 1'b0;
            invert_wheel_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mirb_pkg::CFG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data;
                mirb_pkg::CFG_INVERT_X:      invert_x_reg <= cfg_data[0];
                mirb_pkg::CFG_INVERT_Y:      invert_y_reg <= cfg_data[0];
                mirb_pkg::CFG_INVERT_WHEEL:  invert_wheel_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        timer_inc = 8'd0;
        released = in_data_reg.button_levels
                   & (~{2'b00, in_data_reg.edge_seen} | mirb_pkg::ALWAYS_LEVEL_MASK);

        // debounce: press at once, release after enough quiet ticks
        for (int i = 0; i < mirb_pkg::NUM_BUTTONS; i++)
        begin
            timer_inc = release_timer_reg[i] + 8'd1;
            if (prev_debounced_reg[i] && released[i])
            begin
                release_timer_next[i] = timer_inc;
                prev_debounced_next[i] = timer_inc < debounce_time_reg;
            end
            else
            begin
                release_timer_next[i] = 8'd0;
                prev_debounced_next[i] = !released[i];
            end
        end

        // wheel decode, only stepped when the pins move, no step while the middle button is down
        wheel_state_next = wheel_state_reg;
        last_pins_next = last_pins_reg;
        step = 8'd0;
        if (in_data_reg.wheel_pins != last_pins_reg)
        begin
            wheel_state_next = mirb_pkg::half_step_row(wheel_state_reg[3:0],
                                                       in_data_reg.wheel_pins);
            last_pins_next = in_data_reg.wheel_pins;
            if ((wheel_state_next & mirb_pkg::STEP_DOWN_FLAG) != 8'd0)
                step = 8'hff;
            if ((wheel_state_next & mirb_pkg::STEP_UP_FLAG) != 8'd0)
                step = 8'h01;
        end
        if (prev_debounced_next[mirb_pkg::MIDDLE_BUTTON])
            step = 8'd0;

        changed = (prev_debounced_next != prev_debounced_reg)
                  || (in_data_reg.delta_x != 16'sd0)
                  || (in_data_reg.delta_y != 16'sd0)
                  || (step != 8'd0);

        // busy bank: kill it and pile the new tick on top of the old totals; idle bank: start from zero
        sent_buttons_next = sent_buttons_reg;
        if (in_data_reg.bank_busy)
        begin
            base_buttons = acc_buttons_reg;
            base_x = acc_x_reg;
            base_y = acc_y_reg;
            base_wheel = acc_wheel_reg;
        end
        else
        begin
            if (changed)
                sent_buttons_next = acc_buttons_reg;
            base_buttons = 5'd0;
            base_x = 16'd0;
            base_y = 16'd0;
            base_wheel = 8'd0;
        end

        acc_buttons_next = acc_buttons_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        acc_wheel_next = acc_wheel_reg;
        send = 1'b0;
        if (changed)
        begin
            acc_buttons_next = base_buttons | prev_debounced_next[mirb_pkg::REPORT_BUTTONS-1:0];
            acc_x_next = invert_x_reg ? base_x - in_data_reg.delta_x
                                      : base_x + in_data_reg.delta_x;
            acc_y_next = invert_y_reg ? base_y - in_data_reg.delta_y
                                      : base_y + in_data_reg.delta_y;
            acc_wheel_next = invert_wheel_reg ? base_wheel - step : base_wheel + step;
            send = (acc_buttons_next != sent_buttons_next) || (acc_x_next != 16'd0)
                   || (acc_y_next != 16'd0) || (acc_wheel_next != 8'd0);
        end

        out_data_next.debounced_buttons = prev_debounced_next;
        out_data_next.kill_bank = changed && in_data_reg.bank_busy;
        out_data_next.send_report = send;
        out_data_next.report_buttons = send ? acc_buttons_next : 5'd0;
        out_data_next.report_x = send ? acc_x_next : 16'd0;
        out_data_next.report_y = send ? acc_y_next : 16'd0;
        out_data_next.report_wheel = send ? acc_wheel_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_debounced_reg <= 6'd0;
            for (int i = 0; i < mirb_pkg::NUM_BUTTONS; i++)
                release_timer_reg[i] <= 8'd0;
            wheel_state_reg <= 8'd0;
            last_pins_reg <= 2'd0;
            acc_buttons_reg <= 5'd0;
            sent_buttons_reg <= 5'd0;
            acc_x_reg <= 16'd0;
            acc_y_reg <= 16'd0;
            acc_wheel_reg <= 8'd0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                prev_debounced_reg <= prev_debounced_next;
                for (int i = 0; i < mirb_pkg::NUM_BUTTONS; i++)
                    release_timer_reg[i] <= release_timer_next[i];
                wheel_state_reg <= wheel_state_next;
                last_pins_reg <= last_pins_next;
                acc_buttons_reg <= acc_buttons_next;
                sent_buttons_reg <= sent_buttons_next;
                acc_x_reg <= acc_x_next;
                acc_y_reg <= acc_y_next;
                acc_wheel_reg <= acc_wheel_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule
